[hw/rtl/assert_macros.svh]
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define AFC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// implication checked on every rising clock edge outside reset
`define AFC_ASSERT_IMP(lbl, pre, post, msg) \
  `AFC_ASSERT(lbl, (pre) |-> (post), msg)

`endif

[hw/rtl/afc_pkg.sv]
// types and constants of the box versus frustum cull unit
package afc_pkg;

  localparam int NumPlanes  = 6;
  localparam int PlaneCntW  = (NumPlanes > 1) ? $clog2(NumPlanes) : 1;
  localparam int PlaneIdxW  = 3;
  localparam int NormW      = 16;
  localparam int CoordW     = 32;
  localparam int ProdW      = NormW + CoordW;
  localparam int AccW       = 51;
  localparam int OffsetSh   = 14;

  localparam logic CmdLoad = 1'b0;
  localparam logic CmdTest = 1'b1;

  typedef enum logic [1:0] {
    CullIdle,
    CullRun,
    CullDrain
  } cull_state_e;

  typedef enum logic [1:0] {
    AxisX,
    AxisY,
    AxisZ
  } axis_e;

  typedef logic signed [NormW-1:0]  norm_t;
  typedef logic signed [CoordW-1:0] coord_t;

endpackage

[hw/rtl/aabb_frustum_cull_unit.sv]
// Box versus frustum cull unit: p-vertex test against stored planes
//
// Command channel: a beat is taken at a rising edge where start is high and
// busy is low. command_i selects the kind of beat. A load (CmdLoad) writes
// plane_a_i..plane_d_i into slot plane_index_i at the accepting edge and gives no
// result; slots at or above NumPlanes are ignored. A test (CmdTest) takes the
// box corners and raises busy while one shared 16x32 multiplier with a 51-bit
// accumulator steps through the planes, one normal component per cycle.
// busy stays high while the planes are stepped through and while the last
// product drains, and done_o pulses for one cycle afterwards with
// visible_o. A new beat may be taken in the cycle that done_o is high.
// done_o flags the result for that single cycle only; the receiver has no way to
// hold it off and must take it then.
// Reset clears all planes to zero (so every box is culled until planes are
// loaded), returns the sequencer to idle and drops done_o.
module aabb_frustum_cull_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic                         command_i,
  input  logic [afc_pkg::PlaneIdxW-1:0] plane_index_i,
  input  logic signed [15:0]           plane_a_i,
  input  logic signed [15:0]           plane_b_i,
  input  logic signed [15:0]           plane_c_i,
  input  logic signed [31:0]           plane_d_i,
  input  logic signed [31:0]           box_min_x_i,
  input  logic signed [31:0]           box_min_y_i,
  input  logic signed [31:0]           box_min_z_i,
  input  logic signed [31:0]           box_max_x_i,
  input  logic signed [31:0]           box_max_y_i,
  input  logic signed [31:0]           box_max_z_i,
  output logic                         done_o,
  output logic                         visible_o
);
  import afc_pkg::*;

  `include "assert_macros.svh"

  localparam logic [PlaneCntW-1:0] LastPlane = PlaneCntW'(NumPlanes - 1);

  cull_state_e state_q, state_d;
  logic [PlaneCntW-1:0] plane_q, plane_d;
  axis_e axis_q, axis_d;

  norm_t  norm_a_q [NumPlanes];
  norm_t  norm_b_q [NumPlanes];
  norm_t  norm_c_q [NumPlanes];
  coord_t offset_q [NumPlanes];

  coord_t min_x_q, min_y_q, min_z_q, max_x_q, max_y_q, max_z_q;

  logic accept, load_ok, test_go, issue;
  norm_t  n_sel;
  coord_t p_sel;
  logic signed [ProdW-1:0] prod_d, prod_q;
  coord_t offset_sel, prod_off_q;
  logic prod_vld_q, prod_first_q, prod_last_q;
  logic signed [AccW-1:0] acc_q, acc_base, acc_sum;
  logic nonpos, vis_q, vis_now;
  logic done_d, done_q, visible_q;

  assign busy    = (state_q != CullIdle);
  assign accept  = start && !busy;
  assign load_ok = accept && (command_i == CmdLoad) && (32'(plane_index_i) < NumPlanes);
  assign test_go = accept && (command_i == CmdTest);

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CullIdle;
      plane_q <= '0;
      axis_q  <= AxisX;
    end else begin
      state_q <= state_d;
      plane_q <= plane_d;
      axis_q  <= axis_d;
    end
  end

  always_comb begin
    state_d = state_q;
    plane_d = plane_q;
    axis_d  = axis_q;
    issue   = 1'b0;
    done_d  = 1'b0;
    unique case (state_q)
      CullIdle: begin
        if (test_go) begin
          state_d = CullRun;
          plane_d = '0;
          axis_d  = AxisX;
        end
      end
      CullRun: begin
        issue = 1'b1;
        unique case (axis_q)
          AxisX: axis_d = AxisY;
          AxisY: axis_d = AxisZ;
          default: begin
            axis_d = AxisX;
            if (plane_q == LastPlane) begin
              state_d = CullDrain;
            end else begin
              plane_d = plane_q + 1'b1;
            end
          end
        endcase
      end
      CullDrain: begin
        state_d = CullIdle;
        done_d  = 1'b1;
      end
      default: state_d = CullIdle;
    endcase
  end

  // plane storage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumPlanes; i++) begin
        norm_a_q[i] <= '0;
        norm_b_q[i] <= '0;
        norm_c_q[i] <= '0;
        offset_q[i] <= '0;
      end
    end else if (load_ok) begin
      norm_a_q[PlaneCntW'(plane_index_i)] <= plane_a_i;
      norm_b_q[PlaneCntW'(plane_index_i)] <= plane_b_i;
      norm_c_q[PlaneCntW'(plane_index_i)] <= plane_c_i;
      offset_q[PlaneCntW'(plane_index_i)] <= plane_d_i;
    end
  end

  // box corners held for the whole test
  always_ff @(posedge clk_i) begin
    if (test_go) begin
      min_x_q <= box_min_x_i;
      min_y_q <= box_min_y_i;
      min_z_q <= box_min_z_i;
      max_x_q <= box_max_x_i;
      max_y_q <= box_max_y_i;
      max_z_q <= box_max_z_i;
    end
  end

  // p-vertex pick and shared multiplier
  always_comb begin
    case (axis_q)
      AxisX: begin
        n_sel = norm_a_q[plane_q];
        p_sel = n_sel[NormW-1] ? min_x_q : max_x_q;
      end
      AxisY: begin
        n_sel = norm_b_q[plane_q];
        p_sel = n_sel[NormW-1] ? min_y_q : max_y_q;
      end
      default: begin
        n_sel = norm_c_q[plane_q];
        p_sel = n_sel[NormW-1] ? min_z_q : max_z_q;
      end
    endcase
  end

  assign offset_sel = offset_q[plane_q];
  assign prod_d     = n_sel * p_sel;

  always_ff @(posedge clk_i) begin
    prod_q     <= prod_d;
    prod_off_q <= offset_sel;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q   <= 1'b0;
      prod_first_q <= 1'b0;
      prod_last_q  <= 1'b0;
    end else begin
      prod_vld_q   <= issue;
      prod_first_q <= issue && (axis_q == AxisX);
      prod_last_q  <= issue && (axis_q == AxisZ);
    end
  end

  // accumulate; first term of a plane starts from the aligned offset
  assign acc_base = prod_first_q ? (AccW'(prod_off_q) <<< OffsetSh) : acc_q;
  assign acc_sum  = acc_base + AccW'(prod_q);
  assign nonpos   = acc_sum[AccW-1] || (acc_sum == '0);
  assign vis_now  = vis_q && !(prod_vld_q && prod_last_q && nonpos);

  always_ff @(posedge clk_i) begin
    if (prod_vld_q) begin
      acc_q <= acc_sum;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vis_q <= 1'b1;
    end else if (test_go) begin
      vis_q <= 1'b1;
    end else begin
      vis_q <= vis_now;
    end
  end

  // result beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done_d) begin
      visible_q <= vis_now;
    end
  end

  assign done_o    = done_q;
  assign visible_o = visible_q;

  `AFC_ASSERT_IMP(a_done_idle, done_o, !busy, "result beat while busy")
  `AFC_ASSERT_IMP(a_test_busy, start && !busy && command_i == CmdTest, ##1 busy,
                  "test beat did not start the sequencer")
  `AFC_ASSERT_IMP(a_done_follows, $fell(busy), done_o, "sequencer ended without result beat")
  `AFC_ASSERT_IMP(a_done_single, done_o, ##1 !done_o, "result beat lasted two cycles")

endmodule
